// ===== rtl/core/kic_pkg.sv =====
package kic_pkg;

    // Key codes of the keypad, ASCII.
    localparam logic [7:0] KEY_ZERO   = 8'd48;
    localparam logic [7:0] KEY_NINE   = 8'd57;
    localparam logic [7:0] KEY_PLUS   = 8'h2B;
    localparam logic [7:0] KEY_MINUS  = 8'h2D;
    localparam logic [7:0] KEY_SLASH  = 8'h2F;
    localparam logic [7:0] KEY_STAR   = 8'h2A;
    localparam logic [7:0] KEY_PCT    = 8'h25;
    localparam logic [7:0] KEY_CARET  = 8'h5E;
    localparam logic [7:0] KEY_BAR    = 8'h7C;
    localparam logic [7:0] KEY_AMP    = 8'h26;
    localparam logic [7:0] KEY_EQUALS = 8'h3D;

    // Operand limits.
    localparam int          OPND_W   = 31;
    localparam int          ANS_W    = 36;
    localparam int          RADIX    = 10;

    // Iteration counts of the shared add/subtract unit.
    localparam int          MUL_STEPS = 31;
    localparam int          DIV_STEPS = 36;

    // Operator codes, in the order the keypad lists them.
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_DIV = 3'd2,
        OP_MUL = 3'd3,
        OP_MOD = 3'd4,
        OP_XOR = 3'd5,
        OP_OR  = 3'd6,
        OP_AND = 3'd7
    } op_code_t;

    typedef struct packed {
        logic     hit;
        op_code_t code;
    } op_hit_t;

    // Maps a key to its operator code, if it is an operator key.
    function automatic op_hit_t op_lookup(input logic [7:0] key);
        op_hit_t r;
        r.hit  = 1'b1;
        r.code = OP_ADD;
        case (key)
            KEY_PLUS:  r.code = OP_ADD;
            KEY_MINUS: r.code = OP_SUB;
            KEY_SLASH: r.code = OP_DIV;
            KEY_STAR:  r.code = OP_MUL;
            KEY_PCT:   r.code = OP_MOD;
            KEY_CARET: r.code = OP_XOR;
            KEY_BAR:   r.code = OP_OR;
            KEY_AMP:   r.code = OP_AND;
            default:   r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/keystroke_integer_calculator.sv =====
// Keypad integer calculator. Keys arrive one per request in the form
// VALUE OPERATOR VALUE '=', and every accepted key is echoed as one output
// request; keys that do not fit the expression at that point are taken and
// dropped without output. Digits, operator keys and '=' for + - ^ | & are
// answered straight from the idle state. '=' for *, / and % runs on the one
// shared 34-bit add/subtract unit, which retires one bit of the product or
// quotient per cycle; in_ready stays low while it runs. The
// input also waits while a finished output request has not been taken.
// Sums, differences, products, remainders and bitwise results wrap to
// DATA_WIDTH bits; division returns the quotient in tenths, rounded half up.
module keystroke_integer_calculator
    import kic_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         key_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         echo_char,
    output logic               answer_valid,
    output logic signed [35:0] answer,
    output logic               answer_in_tenths
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_RUN    = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    localparam logic [63:0] WRAP_MASK = {64{1'b1}} >> (64 - DATA_WIDTH);
    localparam logic [5:0]  MUL_LAST  = 6'(MUL_STEPS - 1);
    localparam logic [5:0]  DIV_LAST  = 6'(DIV_STEPS - 1);

    // Sign-extends a value from DATA_WIDTH bits and keeps the answer bits.
    function automatic logic [ANS_W-1:0] wrap_data(input logic [63:0] v);
        logic [63:0] w;
        w = v & WRAP_MASK;
        if (v[DATA_WIDTH-1])
        begin
            w = w | ~WRAP_MASK;
        end
        return w[ANS_W-1:0];
    endfunction

    state_t              state_reg,  state_next;
    logic                phase_reg,  phase_next;
    logic [OPND_W-1:0]   first_reg,  first_next;
    logic [OPND_W-1:0]   second_reg, second_next;
    op_code_t            op_reg,     op_next;
    op_code_t            job_reg,    job_next;
    logic [5:0]          cnt_reg,    cnt_next;
    logic [32:0]         rem_reg,    rem_next;
    logic [35:0]         shf_reg,    shf_next;
    logic [31:0]         mcand_reg,  mcand_next;

    logic                ovalid_reg, ovalid_next;
    logic [7:0]          echo_reg,   echo_next;
    logic                aval_reg,   aval_next;
    logic [ANS_W-1:0]    ans_reg,    ans_next;
    logic                tenths_reg, tenths_next;

    logic                in_take;
    logic                is_digit;
    logic [34:0]         digit_acc;
    logic [OPND_W-1:0]   digit_sat;
    op_hit_t             op_hit;
    logic [63:0]         a64;
    logic [63:0]         b64;
    logic [35:0]         div_num;

    logic                alu_sub;
    logic [32:0]         alu_x;
    logic [32:0]         alu_y;
    logic [33:0]         alu_sum;

    assign in_ready = (state_reg == S_IDLE) && (!ovalid_reg || out_ready);
    assign in_take  = in_valid && in_ready;

    // Decimal digit step: operand * 10 + digit, saturating at 2^31 - 1.
    assign is_digit  = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
    always_comb
    begin
        logic [OPND_W-1:0] acc;
        acc       = phase_reg ? second_reg : first_reg;
        digit_acc = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                  + {31'd0, key_code[3:0] - KEY_ZERO[3:0]};
        digit_sat = (digit_acc[34:OPND_W] != '0) ? {OPND_W{1'b1}} : digit_acc[OPND_W-1:0];
    end

    assign op_hit  = op_lookup(key_code);
    assign a64     = {33'd0, first_reg};
    assign b64     = {33'd0, second_reg};
    // Division works on (20 * a + b) / (2 * b) to round the tenths half up.
    assign div_num = {1'b0, first_reg, 4'b0000} + {3'b000, first_reg, 2'b00}
                   + {5'd0, second_reg};

    // Shared unit: add for shift-and-add multiply, subtract for restoring divide.
    always_comb
    begin
        alu_sub = (job_reg != OP_MUL);
        if (alu_sub)
        begin
            alu_x = {rem_reg[31:0], shf_reg[35]};
            alu_y = {1'b0, mcand_reg};
        end
        else
        begin
            alu_x = rem_reg;
            alu_y = shf_reg[0] ? {1'b0, mcand_reg} : 33'd0;
        end
        alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + {33'd0, alu_sub};
    end

    // Sequencer, operand registers and output register.
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        op_next     = op_reg;
        job_next    = job_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        shf_next    = shf_reg;
        mcand_next  = mcand_reg;
        ovalid_next = ovalid_reg;
        echo_next   = echo_reg;
        aval_next   = aval_reg;
        ans_next    = ans_reg;
        tenths_next = tenths_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    echo_next   = key_code;
                    aval_next   = 1'b0;
                    ans_next    = '0;
                    tenths_next = 1'b0;
                    if (is_digit)
                    begin
                        ovalid_next = 1'b1;
                        if (phase_reg)
                        begin
                            second_next = digit_sat;
                        end
                        else
                        begin
                            first_next = digit_sat;
                        end
                    end
                    else if (!phase_reg)
                    begin
                        if ((first_reg != '0) && op_hit.hit)
                        begin
                            ovalid_next = 1'b1;
                            op_next     = op_hit.code;
                            phase_next  = 1'b1;
                        end
                    end
                    else if ((key_code == KEY_EQUALS) && (second_reg != '0))
                    begin
                        // The expression is complete: clear the operand state.
                        phase_next  = 1'b0;
                        first_next  = '0;
                        second_next = '0;
                        op_next     = OP_ADD;
                        job_next    = op_reg;
                        cnt_next    = '0;
                        rem_next    = '0;
                        case (op_reg)
                            OP_MUL:
                            begin
                                shf_next   = {5'd0, second_reg};
                                mcand_next = {1'b0, first_reg};
                                state_next = S_RUN;
                            end
                            OP_DIV:
                            begin
                                shf_next   = div_num;
                                mcand_next = {second_reg, 1'b0};
                                state_next = S_RUN;
                            end
                            OP_MOD:
                            begin
                                shf_next   = {5'd0, first_reg};
                                mcand_next = {1'b0, second_reg};
                                state_next = S_RUN;
                            end
                            OP_ADD:
                            begin
                                ovalid_next = 1'b1;
                                aval_next   = 1'b1;
                                ans_next    = wrap_data(a64 + b64);
                            end
                            OP_SUB:
                            begin
                                ovalid_next = 1'b1;
                                aval_next   = 1'b1;
                                ans_next    = wrap_data(a64 - b64);
                            end
                            OP_XOR:
                            begin
                                ovalid_next = 1'b1;
                                aval_next   = 1'b1;
                                ans_next    = wrap_data(a64 ^ b64);
                            end
                            OP_OR:
                            begin
                                ovalid_next = 1'b1;
                                aval_next   = 1'b1;
                                ans_next    = wrap_data(a64 | b64);
                            end
                            default:
                            begin
                                ovalid_next = 1'b1;
                                aval_next   = 1'b1;
                                ans_next    = wrap_data(a64 & b64);
                            end
                        endcase
                    end
                end
            end

            S_RUN:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (alu_sub)
                begin
                    // One quotient bit per cycle.
                    rem_next = alu_sum[33] ? alu_sum[32:0] : {rem_reg[31:0], shf_reg[35]};
                    shf_next = {shf_reg[34:0], alu_sum[33]};
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    // One multiplier bit per cycle, product shifting right.
                    rem_next = alu_sum[33:1];
                    shf_next = {alu_sum[0], shf_reg[35:1]};
                    if (cnt_reg == MUL_LAST)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                ovalid_next = 1'b1;
                echo_next   = KEY_EQUALS;
                aval_next   = 1'b1;
                tenths_next = 1'b0;
                case (job_reg)
                    OP_DIV:
                    begin
                        ans_next    = shf_reg;
                        tenths_next = 1'b1;
                    end
                    OP_MUL:
                    begin
                        ans_next = wrap_data({2'b00, rem_reg[30:0], shf_reg[35:5]});
                    end
                    default:
                    begin
                        ans_next = wrap_data({32'd0, rem_reg[31:0]});
                    end
                endcase
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
            op_reg     <= OP_ADD;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            op_reg     <= op_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        rem_reg    <= rem_next;
        shf_reg    <= shf_next;
        mcand_reg  <= mcand_next;
        echo_reg   <= echo_next;
        aval_reg   <= aval_next;
        ans_reg    <= ans_next;
        tenths_reg <= tenths_next;
    end

    assign out_valid        = ovalid_reg;
    assign echo_char        = echo_reg;
    assign answer_valid     = aval_reg;
    assign answer           = $signed(ans_reg);
    assign answer_in_tenths = tenths_reg;

endmodule

// ===== rtl/core/kic_checker.sv =====
module kic_checker
    import kic_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [7:0]         key_code,
    input logic               out_valid,
    input logic               out_ready,
    input logic [7:0]         echo_char,
    input logic               answer_valid,
    input logic signed [35:0] answer,
    input logic               answer_in_tenths
);

    // A key request that is not taken keeps waiting with the same key.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(key_code))
        else $error("input request changed before it was taken");

    // A request that is not taken holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(echo_char) && $stable(answer))
        else $error("output request changed before it was taken");

    // Only the equals key carries an answer.
    a_ans_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && answer_valid |-> echo_char == KEY_EQUALS)
        else $error("answer on a key other than equals");

    // Echo-only requests carry a zero answer.
    a_ans_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !answer_valid |-> answer == 36'sd0 && !answer_in_tenths)
        else $error("answer fields set without an answer");

    // A quotient in tenths is an answer and never negative.
    a_tenths: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && answer_in_tenths |-> answer_valid && !answer[35])
        else $error("bad tenths result");

endmodule

bind keystroke_integer_calculator kic_checker u_kic_checker (.*);
